/* rtl/core/letter_trie_engine_defines.svh */
// ----------------------------------------------------------------------------
// letter_trie_engine_defines.svh
// Assertion macros shared by the letter trie engine RTL.
// ----------------------------------------------------------------------------
`ifndef LETTER_TRIE_ENGINE_DEFINES_SVH
`define LETTER_TRIE_ENGINE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset
`define LTE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset
`define LTE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/lte_pkg.sv */
// ----------------------------------------------------------------------------
// lte_pkg
// Shared types and constants of the letter trie engine.
// ----------------------------------------------------------------------------
package lte_pkg;

    // Fixed field widths of the item and result ports
    localparam int OPCODE_W = 2;
    localparam int LETTER_W = 5;
    localparam int NODES_OUT_W = 11;

    // Queue depths between front, back and result port
    localparam int CMD_Q_DEPTH = 4;
    localparam int RES_Q_DEPTH = 2;

    // Word operations
    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_DELETE = 2'd2,
        OP_PREFIX = 2'd3
    } t_op;

    // Classified item handed from front to back
    typedef struct packed {
        logic                first;   // opens a new word
        t_op                 op;      // operation of the word
        logic                walk;    // valid letter, follow the child entry
        logic                bad;     // letter outside the alphabet
        logic [LETTER_W-1:0] letter;
        logic                last;    // closes the word
    } t_cmd;

    // Result item
    typedef struct packed {
        logic                   found;
        logic                   status;
        logic [NODES_OUT_W-1:0] nodes_in_use;
    } t_res;

    // Back end sequencer states
    typedef enum logic [2:0] {
        BK_INIT,
        BK_IDLE,
        BK_LOOK,
        BK_CLR,
        BK_FIN
    } t_back_state;

endpackage

/* rtl/core/lte_queue.sv */
// ----------------------------------------------------------------------------
// lte_queue
// Small register FIFO with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module lte_queue #(
    parameter int DW    = 8,
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic [DW-1:0] o_data,
    output logic          o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DW-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          push_ok;
    logic          pop_ok;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    // Storage, written on a push transfer
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* rtl/core/lte_front.sv */
// ----------------------------------------------------------------------------
// lte_front
// Accepts items, latches the word operation and classifies each letter.
// ----------------------------------------------------------------------------
module lte_front #(
    parameter int ALPHABET = 26
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic                         i_full,
    input  logic [lte_pkg::OPCODE_W-1:0] i_opcode,
    input  logic [lte_pkg::LETTER_W-1:0] i_letter,
    input  logic                         i_has_letter,
    input  logic                         i_last,
    output logic                         o_cmd_push,
    output lte_pkg::t_cmd                o_cmd
);

    logic          r_at_start;
    lte_pkg::t_op  r_op;
    lte_pkg::t_op  op_eff;
    logic          in_alpha;

    assign o_cmd_push = i_push && !i_full;

    // Opcode counts only on the first item of a word
    assign op_eff   = r_at_start ? lte_pkg::t_op'(i_opcode) : r_op;
    assign in_alpha = (32'(i_letter) < ALPHABET);

    // Classified item
    always_comb begin
        o_cmd.first  = r_at_start;
        o_cmd.op     = op_eff;
        o_cmd.walk   = i_has_letter && in_alpha;
        o_cmd.bad    = i_has_letter && !in_alpha;
        o_cmd.letter = i_letter;
        o_cmd.last   = i_last;
    end

    // Word tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start <= 1'b1;
            r_op       <= lte_pkg::OP_INSERT;
        end else if (o_cmd_push) begin
            r_at_start <= i_last;
            r_op       <= op_eff;
        end
    end

endmodule

/* rtl/core/lte_back.sv */
// ----------------------------------------------------------------------------
// lte_back
// Walks the node pool: child rows and end marks, allocation and results.
// ----------------------------------------------------------------------------
module lte_back #(
    parameter int NODES    = 1024,
    parameter int ALPHABET = 26
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lte_pkg::t_cmd i_cmd,
    input  logic          i_cmd_empty,
    output logic          o_cmd_pop,
    input  logic          i_res_full,
    output logic          o_res_push,
    output lte_pkg::t_res o_res
);

    localparam int NW  = $clog2(NODES);
    localparam int NFW = $clog2(NODES + 1);
    localparam int LW  = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;

    // Node pool: one row of child entries per node, one end mark per node
    logic [ALPHABET-1:0][NW-1:0] r_rows [NODES];
    logic                        r_ends [NODES];

    lte_pkg::t_back_state r_state, n_state;
    logic [NW-1:0]        r_cursor, n_cursor;
    logic                 r_broken, n_broken;
    logic                 r_pool_full, n_pool_full;
    logic [NFW-1:0]       r_next_free, n_next_free;
    lte_pkg::t_op         r_op, n_op;
    logic                 r_last, n_last;
    logic [LW-1:0]        r_lane, n_lane;

    logic [ALPHABET-1:0][NW-1:0] r_row;
    logic                        r_end_q;

    logic          row_we;
    logic          row_clr;
    logic [NW-1:0] row_waddr;
    logic [NW-1:0] row_wdata;
    logic [NW-1:0] row_raddr;
    logic          end_we;
    logic [NW-1:0] end_waddr;
    logic          end_wdata;

    logic [NW-1:0] child;
    logic [NW-1:0] cur_eff;
    logic          brk_eff;
    logic          pf_eff;
    logic          pool_empty;
    logic          valid_end;
    logic [31:0]   letter_ext;
    logic [31:0]   nodes_ext;

    assign child      = r_row[r_lane];
    assign pool_empty = (r_next_free == NFW'(NODES));
    assign valid_end  = !r_broken;
    assign cur_eff    = i_cmd.first ? '0 : r_cursor;
    assign brk_eff    = i_cmd.first ? 1'b0 : r_broken;
    assign pf_eff     = i_cmd.first ? 1'b0 : r_pool_full;
    assign letter_ext = 32'(i_cmd.letter);
    assign nodes_ext  = 32'(r_next_free);

    // Child row memory: lane write or whole-row clear, registered read
    always_ff @(posedge i_clk) begin
        if (row_we) begin
            if (row_clr) begin
                r_rows[row_waddr] <= '0;
            end else begin
                r_rows[row_waddr][r_lane] <= row_wdata;
            end
        end
        r_row <= r_rows[row_raddr];
    end

    // End mark memory, read follows the next cursor
    always_ff @(posedge i_clk) begin
        if (end_we) begin
            r_ends[end_waddr] <= end_wdata;
        end
        r_end_q <= r_ends[n_cursor];
    end

    // Sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lte_pkg::BK_INIT;
            r_cursor    <= '0;
            r_broken    <= 1'b0;
            r_pool_full <= 1'b0;
            r_next_free <= NFW'(1);
            r_op        <= lte_pkg::OP_INSERT;
            r_last      <= 1'b0;
            r_lane      <= '0;
        end else begin
            r_state     <= n_state;
            r_cursor    <= n_cursor;
            r_broken    <= n_broken;
            r_pool_full <= n_pool_full;
            r_next_free <= n_next_free;
            r_op        <= n_op;
            r_last      <= n_last;
            r_lane      <= n_lane;
        end
    end

    // Next state and memory controls
    always_comb begin
        n_state     = r_state;
        n_cursor    = r_cursor;
        n_broken    = r_broken;
        n_pool_full = r_pool_full;
        n_next_free = r_next_free;
        n_op        = r_op;
        n_last      = r_last;
        n_lane      = r_lane;
        row_we      = 1'b0;
        row_clr     = 1'b0;
        row_waddr   = r_cursor;
        row_wdata   = r_next_free[NW-1:0];
        row_raddr   = r_cursor;
        end_we      = 1'b0;
        end_waddr   = r_cursor;
        end_wdata   = 1'b0;
        o_cmd_pop   = 1'b0;
        o_res_push  = 1'b0;
        o_res.found        = 1'b0;
        o_res.status       = 1'b0;
        o_res.nodes_in_use = nodes_ext[lte_pkg::NODES_OUT_W-1:0];

        unique case (r_state)
            // Root row and root end mark cleared once after reset
            lte_pkg::BK_INIT: begin
                row_we    = 1'b1;
                row_clr   = 1'b1;
                row_waddr = '0;
                end_we    = 1'b1;
                end_waddr = '0;
                n_state   = lte_pkg::BK_IDLE;
            end
            // Take the next item; start the child row read for a letter
            lte_pkg::BK_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop   = 1'b1;
                    n_op        = i_cmd.op;
                    n_last      = i_cmd.last;
                    n_lane      = letter_ext[LW-1:0];
                    n_cursor    = cur_eff;
                    n_pool_full = pf_eff;
                    row_raddr   = cur_eff;
                    if (i_cmd.walk && !brk_eff) begin
                        n_broken = 1'b0;
                        n_state  = lte_pkg::BK_LOOK;
                    end else begin
                        n_broken = brk_eff || i_cmd.bad;
                        n_state  = i_cmd.last ? lte_pkg::BK_FIN : lte_pkg::BK_IDLE;
                    end
                end
            end
            // Child entry is in; follow it, break the path or allocate
            lte_pkg::BK_LOOK: begin
                n_state = r_last ? lte_pkg::BK_FIN : lte_pkg::BK_IDLE;
                if (child != '0) begin
                    n_cursor = child;
                end else if (r_op != lte_pkg::OP_INSERT) begin
                    n_broken = 1'b1;
                end else if (pool_empty) begin
                    n_broken    = 1'b1;
                    n_pool_full = 1'b1;
                end else begin
                    row_we      = 1'b1;
                    n_cursor    = r_next_free[NW-1:0];
                    n_next_free = r_next_free + 1'b1;
                    n_state     = lte_pkg::BK_CLR;
                end
            end
            // Fresh node: clear its row and end mark
            lte_pkg::BK_CLR: begin
                row_we  = 1'b1;
                row_clr = 1'b1;
                end_we  = 1'b1;
                n_state = r_last ? lte_pkg::BK_FIN : lte_pkg::BK_IDLE;
            end
            // Word end: send the result; insert and delete also update the end mark
            lte_pkg::BK_FIN: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = lte_pkg::BK_IDLE;
                    unique case (r_op)
                        lte_pkg::OP_INSERT: begin
                            end_we       = valid_end;
                            end_wdata    = 1'b1;
                            o_res.status = r_pool_full;
                        end
                        lte_pkg::OP_SEARCH: begin
                            o_res.found = valid_end && r_end_q;
                        end
                        lte_pkg::OP_DELETE: begin
                            end_we    = valid_end;
                            end_wdata = 1'b0;
                        end
                        lte_pkg::OP_PREFIX: begin
                            o_res.found = valid_end;
                        end
                        default: begin
                            o_res.found = 1'b0;
                        end
                    endcase
                end
            end
            default: begin
                n_state = lte_pkg::BK_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/letter_trie_engine.sv */
// ----------------------------------------------------------------------------
// letter_trie_engine
// Trie over a letter alphabet in a node pool, one letter per item.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  items    | push / full        | i_opcode, i_letter, i_has_letter, i_last
//  results  | pop / empty        | o_found, o_status, o_nodes_in_use
//
//  A letter passes the back end as a child row read, then a follow step;
//  an insert that allocates a node adds a step clearing the new node's row.
//  A letterless item, or a letter that cannot be walked, skips the follow;
//  a word's last item adds a result step. The follow uses the registered read.
//  After reset the root is cleared once; other nodes are cleared on allocation.
//  A full result queue stalls the back end; port full rises once 4 items wait.
// ----------------------------------------------------------------------------
`include "letter_trie_engine_defines.svh"

module letter_trie_engine #(
    parameter int NODES    = 1024,
    parameter int ALPHABET = 26
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [lte_pkg::OPCODE_W-1:0]    i_opcode,
    input  logic [lte_pkg::LETTER_W-1:0]    i_letter,
    input  logic                            i_has_letter,
    input  logic                            i_last,
    input  logic                            pop,
    output logic                            empty,
    output logic                            o_found,
    output logic                            o_status,
    output logic [lte_pkg::NODES_OUT_W-1:0] o_nodes_in_use
);

    localparam int CMD_W = $bits(lte_pkg::t_cmd);
    localparam int RES_W = $bits(lte_pkg::t_res);

    logic          cmd_push;
    lte_pkg::t_cmd cmd_in;
    lte_pkg::t_cmd cmd_out;
    logic          cmd_full;
    logic          cmd_empty;
    logic          cmd_pop;
    logic          res_push;
    lte_pkg::t_res res_in;
    lte_pkg::t_res res_out;
    logic          res_full;

    assign full = cmd_full;

    // Front: accept and classify
    lte_front #(
        .ALPHABET (ALPHABET)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (cmd_full),
        .i_opcode     (i_opcode),
        .i_letter     (i_letter),
        .i_has_letter (i_has_letter),
        .i_last       (i_last),
        .o_cmd_push   (cmd_push),
        .o_cmd        (cmd_in)
    );

    // Item queue between front and back
    lte_queue #(
        .DW    (CMD_W),
        .DEPTH (lte_pkg::CMD_Q_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out),
        .o_empty (cmd_empty)
    );

    // Back: trie walk
    lte_back #(
        .NODES    (NODES),
        .ALPHABET (ALPHABET)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_out),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    // Result queue
    lte_queue #(
        .DW    (RES_W),
        .DEPTH (lte_pkg::RES_Q_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_found        = res_out.found;
    assign o_status       = res_out.status;
    assign o_nodes_in_use = res_out.nodes_in_use;

    // Checks
    `LTE_ASSERT_IMP(a_res_push_room, i_clk, i_rst_n, res_push, !res_full, "result pushed into full queue")
    `LTE_ASSERT_IMP(a_cmd_pop_avail, i_clk, i_rst_n, cmd_pop, !cmd_empty, "item taken from empty queue")
    `LTE_ASSERT_IMP(a_status_no_found, i_clk, i_rst_n, !empty && o_status, !o_found, "pool exhausted with found set")
    `LTE_ASSERT_NXT(a_pop_then_push, i_clk, i_rst_n, cmd_pop && cmd_out.walk && !cmd_out.last, !res_push, "result pushed right after a non-final letter")

endmodule

/* tb/letter_trie_engine_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// letter_trie_engine_tb
// Self-checking bench for the letter trie engine. A directed table covers
// empty words, invalid letters, broken paths and delete. Random words follow,
// most of them reusing stored words, across four idling phases. One phase
// fills the node pool. Each popped result is checked against a hand-typed
// value for typed directed rows, else against a behavioral trie kept in the bench.
// ----------------------------------------------------------------------------
module letter_trie_engine_tb;

    localparam int NODES       = 1024;
    localparam int ALPHA       = 26;
    localparam int MAXW        = 12;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 100;
    localparam int WORD_STORE  = 64;

    // one input item
    typedef struct packed {
        lte_pkg::t_op                 op;
        logic [lte_pkg::LETTER_W-1:0] letter;
        logic                         has_letter;
        logic                         last;
    } t_item;

    // directed row: item plus an optional hand-typed result
    typedef struct packed {
        lte_pkg::t_op                    op;
        logic [lte_pkg::LETTER_W-1:0]    letter;
        logic                            has_letter;
        logic                            last;
        logic                            typed;
        logic                            found;
        logic                            status;
        logic [lte_pkg::NODES_OUT_W-1:0] nodes;
    } t_dir_row;

    // a word for the random part
    typedef struct packed {
        logic [3:0]                             len;
        logic [MAXW-1:0][lte_pkg::LETTER_W-1:0] ch;
    } t_word;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            push;
    logic                            full;
    logic [lte_pkg::OPCODE_W-1:0]    i_opcode;
    logic [lte_pkg::LETTER_W-1:0]    i_letter;
    logic                            i_has_letter;
    logic                            i_last;
    logic                            pop;
    logic                            empty;
    logic                            o_found;
    logic                            o_status;
    logic [lte_pkg::NODES_OUT_W-1:0] o_nodes_in_use;

    letter_trie_engine uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_opcode       (i_opcode),
        .i_letter       (i_letter),
        .i_has_letter   (i_has_letter),
        .i_last         (i_last),
        .pop            (pop),
        .empty          (empty),
        .o_found        (o_found),
        .o_status       (o_status),
        .o_nodes_in_use (o_nodes_in_use)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // behavioral trie, reset state at declaration
    bit [9:0]     kid_tab [NODES*ALPHA];
    bit           end_mark [NODES];
    int unsigned  free_node     = 1;
    int unsigned  cur_node      = 0;
    bit           path_lost     = 1'b0;
    bit           pool_hit      = 1'b0;
    lte_pkg::t_op word_op       = lte_pkg::OP_INSERT;
    bit           between_words = 1'b1;

    lte_pkg::t_res pending_replies [$];
    t_word         known_words [$];

    int fails       = 0;
    int items_sent  = 0;
    int replies_ok  = 0;
    int found_seen  = 0;
    int pool_out_seen = 0;
    int idle_pct    = 0;
    int stall_pct   = 0;
    int hold_left   = 0;
    bit hold_req    = 1'b0;

    const t_dir_row dir_tab [26] = '{
        // empty words on a fresh trie
        '{lte_pkg::OP_SEARCH, 5'd0,  1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 11'd1},
        '{lte_pkg::OP_PREFIX, 5'd0,  1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 11'd1},
        '{lte_pkg::OP_DELETE, 5'd0,  1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 11'd1},
        // highest letter
        '{lte_pkg::OP_INSERT, 5'd25, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 11'd2},
        '{lte_pkg::OP_SEARCH, 5'd25, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 11'd2},
        // root as end of the empty word
        '{lte_pkg::OP_INSERT, 5'd0,  1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 11'd2},
        '{lte_pkg::OP_SEARCH, 5'd0,  1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 11'd2},
        '{lte_pkg::OP_DELETE, 5'd31, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 11'd2},
        '{lte_pkg::OP_SEARCH, 5'd0,  1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 11'd2},
        // letterless opener latches insert, later opcodes ignored: "ab"
        '{lte_pkg::OP_INSERT, 5'd31, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 11'd0},
        '{lte_pkg::OP_PREFIX, 5'd0,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 11'd0},
        '{lte_pkg::OP_SEARCH, 5'd1,  1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 11'd4},
        '{lte_pkg::OP_PREFIX, 5'd0,  1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 11'd4},
        '{lte_pkg::OP_SEARCH, 5'd0,  1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 11'd4},
        '{lte_pkg::OP_SEARCH, 5'd0,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 11'd0},
        '{lte_pkg::OP_INSERT, 5'd1,  1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 11'd4},
        // letters outside the alphabet
        '{lte_pkg::OP_INSERT, 5'd26, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 11'd4},
        '{lte_pkg::OP_SEARCH, 5'd31, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 11'd4},
        '{lte_pkg::OP_PREFIX, 5'd25, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 11'd0},
        '{lte_pkg::OP_INSERT, 5'd30, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 11'd4},
        // delete "ab", then it is gone
        '{lte_pkg::OP_DELETE, 5'd0,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 11'd0},
        '{lte_pkg::OP_SEARCH, 5'd1,  1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 11'd4},
        '{lte_pkg::OP_SEARCH, 5'd0,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 11'd0},
        '{lte_pkg::OP_PREFIX, 5'd1,  1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 11'd4},
        // insert broken by a bad letter after an existing node
        '{lte_pkg::OP_INSERT, 5'd0,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 11'd0},
        '{lte_pkg::OP_DELETE, 5'd31, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 11'd4}
    };

    // advance the trie by one item; returns 1 when the item closes a word
    function automatic bit trie_walk_item(input t_item it, output lte_pkg::t_res r);
        int unsigned slot;
        int unsigned kid;
        r = '0;
        if (between_words) begin
            word_op   = it.op;
            cur_node  = 0;
            path_lost = 1'b0;
            pool_hit  = 1'b0;
        end
        between_words = 1'b0;

        if (it.has_letter && !path_lost) begin
            if (it.letter >= ALPHA) begin
                path_lost = 1'b1;
            end else begin
                slot = cur_node * ALPHA + it.letter;
                kid  = kid_tab[slot];
                if (kid == 0 && word_op != lte_pkg::OP_INSERT) begin
                    path_lost = 1'b1;
                end else if (kid == 0 && free_node >= NODES) begin
                    pool_hit  = 1'b1;
                    path_lost = 1'b1;
                end else begin
                    if (kid == 0) begin
                        kid           = free_node;
                        free_node     = free_node + 1;
                        kid_tab[slot] = kid[9:0];
                        end_mark[kid] = 1'b0;
                    end
                    cur_node = kid;
                end
            end
        end

        if (!it.last)
            return 1'b0;

        case (word_op)
            lte_pkg::OP_INSERT: begin
                if (!path_lost) end_mark[cur_node] = 1'b1;
                r.status = pool_hit;
            end
            lte_pkg::OP_SEARCH: r.found = !path_lost && end_mark[cur_node];
            lte_pkg::OP_DELETE: if (!path_lost) end_mark[cur_node] = 1'b0;
            default:            r.found = !path_lost;
        endcase
        r.nodes_in_use = free_node[lte_pkg::NODES_OUT_W-1:0];

        cur_node      = 0;
        path_lost     = 1'b0;
        pool_hit      = 1'b0;
        between_words = 1'b1;
        return 1'b1;
    endfunction

    function automatic t_word fresh_word(input int unsigned n);
        t_word w;
        w     = '0;
        w.len = n[3:0];
        for (int i = 0; i < n; i++)
            w.ch[i] = lte_pkg::LETTER_W'($urandom_range(ALPHA-1));
        return w;
    endfunction

    // offer one item, with sender gaps; predict at the transfer
    task automatic offer(input t_item it, input bit typed, input lte_pkg::t_res want);
        lte_pkg::t_res r;
        while ($urandom_range(99) < idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push         <= 1'b1;
        i_opcode     <= it.op;
        i_letter     <= it.letter;
        i_has_letter <= it.has_letter;
        i_last       <= it.last;
        do @(posedge i_clk); while (full);
        items_sent++;
        if (trie_walk_item(it, r))
            pending_replies.push_back(typed ? want : r);
    endtask

    // send a word; later items carry random opcodes, some letterless fillers
    task automatic send_word(input lte_pkg::t_op op, input t_word w, input bit lead_blank);
        t_item it;
        bit    first;
        first = 1'b1;
        if (lead_blank) begin
            it = '{op, lte_pkg::LETTER_W'($urandom_range(31)), 1'b0, 1'b0};
            offer(it, 1'b0, '0);
            first = 1'b0;
        end
        if (w.len == 0) begin
            it = '{first ? op : lte_pkg::t_op'($urandom_range(3)),
                   lte_pkg::LETTER_W'($urandom_range(31)), 1'b0, 1'b1};
            offer(it, 1'b0, '0);
        end
        for (int i = 0; i < w.len; i++) begin
            it = '{first ? op : lte_pkg::t_op'($urandom_range(3)), w.ch[i], 1'b1,
                   i == w.len - 1};
            offer(it, 1'b0, '0);
            first = 1'b0;
            if (i != w.len - 1 && $urandom_range(11) == 0) begin
                it = '{lte_pkg::t_op'($urandom_range(3)),
                       lte_pkg::LETTER_W'($urandom_range(31)), 1'b0, 1'b0};
                offer(it, 1'b0, '0);
            end
        end
    endtask

    // mostly stored words under every operation, some fresh and broken ones
    task automatic send_random_word();
        t_word        w;
        lte_pkg::t_op op;
        int unsigned  pick;
        int unsigned  k;
        pick = $urandom_range(99);
        if (known_words.size() == 0 || pick < 40) begin
            op = lte_pkg::OP_INSERT;
            w  = fresh_word($urandom_range(1, 10));
        end else begin
            w = known_words[$urandom_range(known_words.size() - 1)];
            if (pick < 52)      op = lte_pkg::OP_INSERT;
            else if (pick < 70) op = lte_pkg::OP_SEARCH;
            else if (pick < 80) op = lte_pkg::OP_PREFIX;
            else if (pick < 88) op = lte_pkg::OP_DELETE;
            else                op = lte_pkg::t_op'($urandom_range(3));
            k = $urandom_range(9);
            if (k == 0 && w.len > 0) begin
                w.len = w.len - 1;
            end else if (k == 1 && w.len < MAXW) begin
                w.ch[w.len] = lte_pkg::LETTER_W'($urandom_range(ALPHA-1));
                w.len       = w.len + 1;
            end else if (k == 2 && w.len > 0) begin
                w.ch[$urandom_range(w.len - 1)] =
                    lte_pkg::LETTER_W'($urandom_range(ALPHA, 31));
            end else if (k == 3) begin
                w.len = 0;
            end
        end
        send_word(op, w, $urandom_range(9) == 0);
        if (op == lte_pkg::OP_INSERT && w.len != 0) begin
            if (known_words.size() < WORD_STORE)
                known_words.push_back(w);
            else
                known_words[$urandom_range(WORD_STORE - 1)] = w;
        end
    endtask

    // stop offering until every expected result has been popped
    task automatic drain();
        push <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge i_clk);
    endtask

    // result side: check each transfer, random stalls, long hold on request
    always @(posedge i_clk) begin
        lte_pkg::t_res want;
        if (i_rst_n && pop && !empty) begin
            if (pending_replies.size() == 0) begin
                $error("result with no word pending: found=%0d status=%0d nodes=%0d",
                       o_found, o_status, o_nodes_in_use);
                fails++;
            end else begin
                want = pending_replies.pop_front();
                replies_ok++;
                if (want.found)  found_seen++;
                if (want.status) pool_out_seen++;
                if (o_found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, o_found);
                    fails++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    fails++;
                end
                if (o_nodes_in_use !== want.nodes_in_use) begin
                    $error("nodes_in_use: expected %0d, got %0d",
                           want.nodes_in_use, o_nodes_in_use);
                    fails++;
                end
            end
        end
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= stall_pct);
        end
    end

    // stimulus
    initial begin
        t_item         it;
        lte_pkg::t_res want;
        int            goal;
        i_rst_n      <= 1'b0;
        push         <= 1'b0;
        pop          <= 1'b0;
        i_opcode     <= lte_pkg::OP_INSERT;
        i_letter     <= '0;
        i_has_letter <= 1'b0;
        i_last       <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (dir_tab[i]) begin
            it   = '{dir_tab[i].op, dir_tab[i].letter, dir_tab[i].has_letter,
                     dir_tab[i].last};
            want = '{dir_tab[i].found, dir_tab[i].status, dir_tab[i].nodes};
            offer(it, dir_tab[i].typed, want);
        end
        drain();

        // random phases: none (one long hold), sender gaps, receiver stalls, both
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin idle_pct = 0;  stall_pct = 0;  hold_req = 1'b1; end
                1:       begin idle_pct = 60; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 60; end
                default: begin idle_pct = 19; stall_pct = 19; end
            endcase
            // last phase runs the pool dry first
            if (ph == 3) begin
                while (free_node < NODES)
                    send_word(lte_pkg::OP_INSERT, fresh_word(MAXW), 1'b0);
            end
            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal)
                send_random_word();
            drain();
        end

        stall_pct = 0;
        repeat (20) @(posedge i_clk);
        $display("Run covered %0d items and %0d results (%0d found, %0d pool-exhausted).",
                 items_sent, replies_ok, found_seen, pool_out_seen);
        $display("Node pool ended at %0d of %0d in use.", free_node, NODES);
        if (fails == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

/* letter_trie_engine.f */
+incdir+rtl/core
rtl/core/lte_pkg.sv
rtl/core/lte_queue.sv
rtl/core/lte_front.sv
rtl/core/lte_back.sv
rtl/core/letter_trie_engine.sv
tb/letter_trie_engine_tb.sv
